// File: design/dafmt_pkg.sv
`default_nettype none
package dafmt_pkg;

  // Text geometry
  localparam int WORD_BITS   = 32;
  localparam int WORD_DIGITS = 10;
  localparam int MAX_DIGITS  = 10;
  localparam int MAX_TEXT    = 11;
  localparam int CNT_W       = $clog2(WORD_BITS);
  localparam int IDX_W       = $clog2(WORD_DIGITS);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [3:0] MAX_CHARS_RESET = 4'(MAX_TEXT);

  // Request payloads
  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  pad_digits;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       error;
    logic       last;
  } out_item_t;

  // Microcode
  localparam int PC_W = 3;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_DABBLE,
    OP_CHECK,
    OP_SIGN,
    OP_DIGIT,
    OP_NOP,
    OP_ERROR
  } op_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_CNT_NZ,
    COND_ERR,
    COND_IDX_NZ
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  localparam pc_t STEP_WAIT   = 3'd0;
  localparam pc_t STEP_DABBLE = 3'd1;
  localparam pc_t STEP_CHECK  = 3'd2;
  localparam pc_t STEP_SIGN   = 3'd3;
  localparam pc_t STEP_DIGIT  = 3'd4;
  localparam pc_t STEP_DONE   = 3'd5;
  localparam pc_t STEP_ERROR  = 3'd6;

  // Program store: take the jump when the condition holds, else fall through
  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    case (pc)
      STEP_WAIT:   w = '{OP_WAIT,   COND_NONE,   STEP_WAIT};
      STEP_DABBLE: w = '{OP_DABBLE, COND_CNT_NZ, STEP_DABBLE};
      STEP_CHECK:  w = '{OP_CHECK,  COND_ERR,    STEP_ERROR};
      STEP_SIGN:   w = '{OP_SIGN,   COND_NONE,   STEP_WAIT};
      STEP_DIGIT:  w = '{OP_DIGIT,  COND_IDX_NZ, STEP_DIGIT};
      STEP_DONE:   w = '{OP_NOP,    COND_ALWAYS, STEP_WAIT};
      STEP_ERROR:  w = '{OP_ERROR,  COND_ALWAYS, STEP_WAIT};
      default:     w = '{OP_NOP,    COND_ALWAYS, STEP_WAIT};
    endcase
    return w;
  endfunction

  // Datapath strobes from the sequencer
  typedef struct packed {
    logic load;
    logic dabble;
    logic check;
    logic idx_dec;
  } ctl_t;

  // Datapath status back to the sequencer
  typedef struct packed {
    logic       cnt_nz;
    logic       err;
    logic       neg;
    logic       idx_nz;
    logic [3:0] digit;
  } stat_t;

endpackage
`default_nettype wire

// File: design/dafmt_datapath.sv
`default_nettype none
module dafmt_datapath
  import dafmt_pkg::*;
(
  input  wire logic     clk,
  input  wire in_item_t in_data,
  input  wire logic [3:0] max_chars,
  input  wire ctl_t     ctl,
  output stat_t         stat
);

  logic [WORD_BITS-1:0]         bin;
  logic [WORD_DIGITS-1:0][3:0]  bcd;
  logic [CNT_W-1:0]             cnt;
  logic                         neg;
  logic [3:0]                   pad;
  logic [IDX_W-1:0]             idx;

  logic                         load_neg;
  logic [WORD_DIGITS-1:0][3:0]  adj;
  logic [WORD_DIGITS-1:0][3:0]  bcd_next;
  logic [3:0]                   ndig;
  logic [3:0]                   limit;
  logic [3:0]                   total;
  logic [3:0]                   idx_start;
  logic                         err;

  assign load_neg = (in_data.pad_digits == 4'd0) && in_data.value[WORD_BITS-1];

  // Add-3 correction then shift one bit from the binary word into the digits
  always_comb begin
    for (int i = 0; i < WORD_DIGITS; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
    bcd_next[0] = {adj[0][2:0], bin[WORD_BITS-1]};
    for (int i = 1; i < WORD_DIGITS; i++) begin
      bcd_next[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  // Significant digit count, at least one
  always_comb begin
    ndig = 4'd1;
    for (int i = 0; i < WORD_DIGITS; i++) begin
      if (bcd[i] != 4'd0) begin
        ndig = 4'(i + 1);
      end
    end
  end

  // Length and width checks
  always_comb begin
    limit = (max_chars > 4'(MAX_TEXT)) ? 4'(MAX_TEXT) : max_chars;
    if (pad == 4'd0) begin
      total     = ndig + {3'd0, neg};
      idx_start = ndig - 4'd1;
    end else begin
      total     = pad;
      idx_start = pad - 4'd1;
    end
    err = (pad > 4'(MAX_DIGITS)) || ((pad != 4'd0) && (ndig > pad)) ||
          (total > limit) || (total > 4'(MAX_TEXT));
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      neg <= load_neg;
      bin <= load_neg ? (~in_data.value + 32'd1) : in_data.value;
      bcd <= '0;
      cnt <= CNT_W'(WORD_BITS - 1);
      pad <= in_data.pad_digits;
    end else if (ctl.dabble) begin
      bcd <= bcd_next;
      bin <= {bin[WORD_BITS-2:0], 1'b0};
      cnt <= cnt - CNT_W'(1);
    end
    if (ctl.check) begin
      idx <= idx_start[IDX_W-1:0];
    end else if (ctl.idx_dec) begin
      idx <= idx - IDX_W'(1);
    end
  end

  assign stat.cnt_nz = (cnt != '0);
  assign stat.err    = err;
  assign stat.neg    = neg;
  assign stat.idx_nz = (idx != '0);
  assign stat.digit  = bcd[idx];

endmodule
`default_nettype wire

// File: design/decimal_ascii_formatter_top.sv
`default_nettype none
// Decimal ASCII formatter.
// in channel (in_valid/in_ready/in_data): one 32-bit word and a pad width per
// request. out channel (out_valid/out_ready/out_data): one character per
// request, most significant first, last set on the final one; a refused
// conversion gives one request with error and last set and a zero character.
// cfg channel (cfg_valid/cfg_ready/cfg_data): writes max_chars; always ready,
// write it only while the formatter is idle.
// The sequencer takes a word at its wait step, then runs a shift-add-3 step
// for each of the 32 word bits in the digit register, a check step, a sign
// step that also carries any minus sign, a digit step repeated for each digit
// and a closing step. An error result goes from the check step to the error
// step, which emits it, and then back to the wait step.
// The character register decouples the receiver: a stall on out_ready holds
// the sequencer at its emit step and the pending character stays put; the
// next word can be taken while the final character still waits.
// Reset (synchronous, rst high) returns the sequencer to its wait step, drops
// out_valid and sets max_chars to 11.
module decimal_ascii_formatter_top
  import dafmt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [3:0] cfg_data
);

  pc_t        pc;
  pc_t        pc_next;
  uword_t     uword;
  logic [3:0] max_chars;
  ctl_t       ctl;
  stat_t      stat;
  logic       slot_free;
  logic       emit;
  out_item_t  emit_data;
  logic       stall;
  logic       take;

  dafmt_datapath u_datapath (
    .clk       (clk),
    .in_data   (in_data),
    .max_chars (max_chars),
    .ctl       (ctl),
    .stat      (stat)
  );

  assign uword     = ucode_rom(pc);
  assign slot_free = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  // Decode the control word
  always_comb begin
    in_ready  = 1'b0;
    ctl       = '0;
    emit      = 1'b0;
    emit_data = '0;
    stall     = 1'b0;
    case (uword.op)
      OP_WAIT: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
        stall    = !in_valid;
      end
      OP_DABBLE: begin
        ctl.dabble = 1'b1;
      end
      OP_CHECK: begin
        ctl.check = 1'b1;
      end
      OP_SIGN: begin
        if (stat.neg) begin
          stall               = !slot_free;
          emit                = slot_free;
          emit_data.char_code = CHAR_MINUS;
        end
      end
      OP_DIGIT: begin
        stall               = !slot_free;
        emit                = slot_free;
        ctl.idx_dec         = slot_free;
        emit_data.char_code = CHAR_ZERO + {4'd0, stat.digit};
        emit_data.last      = !stat.idx_nz;
      end
      OP_ERROR: begin
        stall           = !slot_free;
        emit            = slot_free;
        emit_data.error = 1'b1;
        emit_data.last  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Jump condition
  always_comb begin
    case (uword.cond)
      COND_ALWAYS: take = 1'b1;
      COND_CNT_NZ: take = stat.cnt_nz;
      COND_ERR:    take = stat.err;
      COND_IDX_NZ: take = stat.idx_nz;
      default:     take = 1'b0;
    endcase
  end

  // Step counter
  always_comb begin
    if (stall) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = uword.target;
    end else begin
      pc_next = pc + pc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  // Character register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      out_data <= emit_data;
    end
  end

  // Length limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars <= MAX_CHARS_RESET;
    end else if (cfg_valid) begin
      max_chars <= cfg_data;
    end
  end

endmodule
`default_nettype wire

// File: tb/dafmt_text_checker.sv
`timescale 1ns / 100ps
// Watches the word, character and limit channels of the formatter, predicts
// the character stream of every accepted word and compares it in order.
module dafmt_text_checker
  import dafmt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire in_item_t   in_data,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire out_item_t  out_data,
  input  wire logic       cfg_valid,
  input  wire logic       cfg_ready,
  input  wire logic [3:0] cfg_data,
  output int              fail_count,
  output int              pending
);

  out_item_t   expected_chars[$];
  logic [3:0]  char_limit = MAX_CHARS_RESET;
  int          mismatches = 0;
  out_item_t   want;

  // Expected characters of one word, most significant first
  function automatic void format_decimal(input in_item_t req, input logic [3:0] limit_reg);
    logic [31:0] mag;
    logic        neg;
    logic        refused;
    logic [3:0]  digits[WORD_DIGITS];
    int          ndig;
    int          total;
    int          fill;
    int          limit;
    int          k;
    int          pos;
    logic [7:0]  text[MAX_TEXT];
    out_item_t   ch;

    limit   = (int'(limit_reg) > MAX_TEXT) ? MAX_TEXT : int'(limit_reg);
    neg     = 1'b0;
    refused = 1'b0;
    mag     = req.value;
    if (req.pad_digits == 4'd0) begin
      neg = req.value[31];
      if (neg) mag = 32'd0 - req.value;
    end else if (int'(req.pad_digits) > MAX_DIGITS) begin
      refused = 1'b1;
    end

    // least significant digit first
    ndig = 0;
    do begin
      digits[ndig] = 4'(mag % 32'd10);
      mag = mag / 32'd10;
      ndig++;
    end while (mag != 0 && ndig < WORD_DIGITS);

    if (req.pad_digits == 4'd0) begin
      total = ndig + (neg ? 1 : 0);
      fill  = 0;
    end else begin
      if (ndig > int'(req.pad_digits)) refused = 1'b1;
      total = int'(req.pad_digits);
      fill  = total - ndig;
    end
    if (total > limit || total > MAX_TEXT) refused = 1'b1;

    if (refused) begin
      ch = '{char_code: 8'h00, error: 1'b1, last: 1'b1};
      expected_chars.push_back(ch);
    end else begin
      pos = 0;
      if (neg) begin
        text[pos] = CHAR_MINUS;
        pos++;
      end
      for (k = 0; k < fill; k++) begin
        text[pos] = CHAR_ZERO;
        pos++;
      end
      for (k = ndig; k > 0; k--) begin
        text[pos] = CHAR_ZERO + 8'(digits[k-1]);
        pos++;
      end
      for (k = 0; k < pos; k++) begin
        ch = '{char_code: text[k], error: 1'b0, last: (k + 1 == pos)};
        expected_chars.push_back(ch);
      end
    end
  endfunction

  // Track the limit, predict on word requests, compare on character requests
  always @(posedge clk) begin
    if (rst) begin
      char_limit = MAX_CHARS_RESET;
      expected_chars.delete();
      pending    <= 0;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) char_limit = cfg_data;
      if (in_valid && in_ready) format_decimal(in_data, char_limit);
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected character request: char %h error %b last %b",
                     out_data.char_code, out_data.error, out_data.last);
        end else begin
          want = expected_chars.pop_front();
          if (out_data.char_code !== want.char_code || out_data.error !== want.error ||
              out_data.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected char %h error %b last %b, got char %h error %b last %b",
                       want.char_code, want.error, want.last,
                       out_data.char_code, out_data.error, out_data.last);
          end
        end
      end
      pending    <= expected_chars.size();
      fail_count <= mismatches;
    end
  end

endmodule

// File: tb/decimal_ascii_formatter_top_tb.sv
`timescale 1ns / 100ps
module decimal_ascii_formatter_top_tb;
  import dafmt_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 60;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_data = '0;
  int         fail_count;
  int         pending;
  int         send_idle = 20;
  int         recv_idle = 83;

  decimal_ascii_formatter_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  dafmt_text_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Present one word with random gaps ahead of it; returns once accepted
  task automatic send_word(input logic [31:0] value, input logic [3:0] pad);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{value: value, pad_digits: pad};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait for every predicted character, then let it settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Limit write, only with the formatter idle
  task automatic write_limit(input logic [3:0] limit);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= limit;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly signed words, some padded, a few refused widths
  task automatic send_random_word();
    logic [3:0]      pad;
    logic [31:0]     value;
    longint unsigned span;
    int              pick;

    pick = $urandom_range(99);
    if (pick < 55) pad = 4'd0;
    else if (pick < 90) pad = 4'($urandom_range(1, MAX_DIGITS));
    else pad = 4'($urandom_range(MAX_DIGITS + 1, 15));

    pick = $urandom_range(99);
    if (pick < 35) begin
      value = $urandom;
    end else if (pick < 60 && pad != 4'd0 && int'(pad) <= MAX_DIGITS) begin
      // fits the pad width
      span = 1;
      repeat (pad) span = span * 10;
      value = 32'(longint'($urandom) % span);
    end else if (pick < 80) begin
      value = $urandom_range(0, 999);
    end else begin
      value = 32'd0 - 32'($urandom_range(1, 99999));
    end
    send_word(value, pad);
  endtask

  initial begin
    logic [3:0] phase_limits[9];

    phase_limits = '{4'd11, 4'd0, 4'd1, 4'd15, 4'd6, 4'd12, 4'd10, 4'd11, 4'd9};
    phase_limits[7] = 4'($urandom_range(0, 15));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: signed extremes and the most negative word
    send_word(32'd0, 4'd0);
    send_word(32'd1, 4'd0);
    send_word(32'd9, 4'd0);
    send_word(32'd10, 4'd0);
    send_word(32'h7FFF_FFFF, 4'd0);
    send_word(32'h8000_0000, 4'd0);
    send_word(32'hFFFF_FFFF, 4'd0);
    send_word(32'd1234567890, 4'd0);
    send_word(32'd0 - 32'd1000000000, 4'd0);
    // padded mode reads the word as unsigned
    send_word(32'hFFFF_FFFF, 4'd10);
    send_word(32'd0, 4'd1);
    send_word(32'd0, 4'd10);
    send_word(32'd12345, 4'd5);
    send_word(32'd7, 4'd3);
    send_word(32'd99, 4'd2);
    // digits exceed the width
    send_word(32'd10, 4'd1);
    send_word(32'd12345, 4'd4);
    send_word(32'd1000000000, 4'd9);
    // width too large
    send_word(32'd5, 4'd11);
    send_word(32'hFFFF_FFFF, 4'd15);

    // Text too long, sign counted toward the limit
    write_limit(4'd3);
    send_word(32'd999, 4'd0);
    send_word(32'd1000, 4'd0);
    send_word(32'd0 - 32'd99, 4'd0);
    send_word(32'd5, 4'd4);

    // Random phases over several limits and idle patterns
    for (int p = 0; p < 9; p++) begin
      write_limit(phase_limits[p]);
      case (p / 3)
        0: begin
          send_idle = 20;
          recv_idle = 83;
        end
        1: begin
          send_idle = 83;
          recv_idle = 20;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      repeat (14) send_random_word();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: decimal_ascii_formatter_top.f
design/dafmt_pkg.sv
design/dafmt_datapath.sv
design/decimal_ascii_formatter_top.sv
tb/dafmt_text_checker.sv
tb/decimal_ascii_formatter_top_tb.sv
